// ----- src/ptsd_pkg.sv -----
`timescale 1ns / 1ps

package ptsd_pkg;

  // Geometry of one pixel: four subsamples of three color channels.
  localparam int NUM_LANES = 4;
  localparam int NUM_CH    = 3;

  // Default subsample width (unsigned, 8 fraction bits).
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration register widths.
  localparam int GAIN_W    = 16;
  localparam int SAT_W     = 12;
  localparam int INV_SAT_W = SAT_W + 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = GAIN_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN = 1'b0,
    REG_SAT  = 1'b1
  } cfg_reg_t;

  // Reset values of the registers (1.0 in their formats).
  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd256;
  localparam logic signed [SAT_W-1:0]  SAT_RESET  = 12'sd256;
  localparam logic signed [INV_SAT_W-1:0] SAT_ONE = 13'sd256;

  // Scaled channel: saturated to +/-(2^39 - 1), 16 fraction bits.
  localparam int X_W = 40;
  localparam longint X_LIMIT = (64'sd1 <<< (X_W - 1)) - 64'sd1;

  // Brightness weights, 16 fraction bits, red/green/blue.
  localparam int WEIGHT_W = 17;
  localparam logic signed [WEIGHT_W-1:0] WEIGHTS [NUM_CH] = '{
    17'sd19595, 17'sd38273, 17'sd9437
  };
  localparam int WP_W   = X_W + WEIGHT_W;
  localparam int WSUM_W = WP_W + 2;
  localparam int Y_FRAC = 16;
  localparam int Y_W    = WSUM_W - Y_FRAC;

  // Blend products and sum, 24 fraction bits.
  localparam int SX_W = X_W + SAT_W;
  localparam int TY_W = Y_W + INV_SAT_W;
  localparam int BL_W = TY_W + 1;

  // Clamped channel 0..2^24 and the four-lane sum.
  localparam int V_W   = 25;
  localparam int ACC_W = V_W + 2;
  localparam logic [V_W-1:0] V_ONE = 25'h100_0000;

  // Scale by 255 and keep the integer part of sum / 4.
  localparam int SCL_W   = ACC_W + 8 - 1;
  localparam int PIX_W   = 8;
  localparam int PIX_LSB = 26;

  // Pipeline depth.
  localparam int LANE_STAGES  = 6;
  localparam int MERGE_STAGES = 2;
  localparam int NUM_STAGES   = LANE_STAGES + MERGE_STAGES;

endpackage

// ----- src/pixel_tone_saturate_downsample_top.sv -----
`timescale 1ns / 1ps
// Throughput: one pixel per cycle while out_tready is high; four subsample
// lanes of six stages each feed a two-stage merge, and every stage holds its
// item only while the next is full.
// Reset (rst_n low, synchronous) empties the pipeline and sets gain and
// saturation to 1.0.

module pixel_tone_saturate_downsample_top #(
  parameter int SAMPLE_BITS = ptsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Configuration write port.
  input  logic                                    cfg_we,
  input  logic [ptsd_pkg::CFG_IDX_W-1:0]          cfg_addr,
  input  logic [ptsd_pkg::CFG_W-1:0]              cfg_wdata,
  // Input stream.
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // From bit 0: s0_red, s0_green, s0_blue, s1_red, s1_green, s1_blue,
  // s2_red, s2_green, s2_blue, s3_red, s3_green, s3_blue, zero pad.
  input  logic [((12*SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  // Output stream.
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // From bit 0: red_out, green_out, blue_out.
  output logic [3*ptsd_pkg::PIX_W-1:0]            out_tdata
);
  import ptsd_pkg::*;

  logic signed [GAIN_W-1:0] gain_r;
  logic signed [SAT_W-1:0]  sat_r;
  logic [NUM_STAGES-1:0]    vld_r;
  logic [NUM_STAGES-1:0]    vld_nxt;
  logic [NUM_STAGES:0]      rdy;

  logic [SAMPLE_BITS-1:0] lane_in [NUM_LANES][NUM_CH];
  logic [V_W-1:0]         lane_v  [NUM_LANES][NUM_CH];
  logic [PIX_W-1:0]       pix     [NUM_CH];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      sat_r  <= SAT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_GAIN: gain_r <= cfg_wdata[GAIN_W-1:0];
        REG_SAT:  sat_r  <= cfg_wdata[SAT_W-1:0];
        default:  ;
      endcase
    end
  end

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    rdy[NUM_STAGES] = out_tready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    vld_nxt[0] = rdy[0] ? in_tvalid : vld_r[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (rdy[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end else begin
        vld_nxt[i] = vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NUM_STAGES-1];

  // One lane for each subsample.
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
      assign lane_in[k][c] = in_tdata[(k*NUM_CH + c)*SAMPLE_BITS +: SAMPLE_BITS];
    end

    ptsd_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk      (clk),
      .stage_en (rdy[LANE_STAGES-1:0]),
      .gain     (gain_r),
      .sat      (sat_r),
      .sample   (lane_in[k]),
      .chan_v   (lane_v[k])
    );
  end

  // Average of the lanes and scaling to display range.
  ptsd_merge u_merge (
    .clk      (clk),
    .stage_en (rdy[NUM_STAGES-1:LANE_STAGES]),
    .lane_v   (lane_v),
    .pix      (pix)
  );

  assign out_tdata = {pix[2], pix[1], pix[0]};

  // An accepted input always lands in the first stage.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted input did not enter the pipeline");

  // A result taken with an empty stage behind it leaves the output empty.
  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !vld_r[NUM_STAGES-2] |=> !out_tvalid)
    else $error("output valid without an item behind it");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid && vld_r == '0)
    else $error("pipeline not empty after reset");

endmodule

// ----- src/ptsd_lane.sv -----
`timescale 1ns / 1ps

module ptsd_lane #(
  parameter int SAMPLE_BITS = ptsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic [ptsd_pkg::LANE_STAGES-1:0]      stage_en,
  input  logic signed [ptsd_pkg::GAIN_W-1:0]    gain,
  input  logic signed [ptsd_pkg::SAT_W-1:0]     sat,
  input  logic [SAMPLE_BITS-1:0]                sample [ptsd_pkg::NUM_CH],
  output logic [ptsd_pkg::V_W-1:0]              chan_v [ptsd_pkg::NUM_CH]
);
  import ptsd_pkg::*;

  localparam int PW = SAMPLE_BITS + GAIN_W + 1;
  localparam int EW = (PW > X_W) ? PW : X_W;

  logic signed [PW-1:0]     prod_r   [NUM_CH];
  logic signed [X_W-1:0]    x_nxt    [NUM_CH];
  logic signed [X_W-1:0]    x_r      [NUM_CH];
  logic signed [X_W-1:0]    x3_r     [NUM_CH];
  logic signed [X_W-1:0]    x4_r     [NUM_CH];
  logic signed [WP_W-1:0]   wp_r     [NUM_CH];
  logic signed [WSUM_W-1:0] wsum;
  logic signed [Y_W-1:0]    y_r;
  logic signed [INV_SAT_W-1:0] inv_sat;
  logic signed [SX_W-1:0]   sx_r     [NUM_CH];
  logic signed [TY_W-1:0]   ty_r;
  logic signed [BL_W-1:0]   blend    [NUM_CH];
  logic [V_W-1:0]           v_r      [NUM_CH];

  logic signed [EW-1:0] ext_prod [NUM_CH];
  logic signed [EW-1:0] lim_pos;
  logic signed [EW-1:0] lim_neg;

  // Saturation of the scaled channel.
  always_comb begin
    lim_pos = EW'(X_LIMIT);
    lim_neg = -lim_pos;
    for (int c = 0; c < NUM_CH; c++) begin
      ext_prod[c] = EW'(prod_r[c]);
      if (ext_prod[c] > lim_pos) begin
        x_nxt[c] = X_W'(lim_pos);
      end else if (ext_prod[c] < lim_neg) begin
        x_nxt[c] = X_W'(lim_neg);
      end else begin
        x_nxt[c] = X_W'(ext_prod[c]);
      end
    end
  end

  // Brightness as a floor shift of the weighted sum.
  assign wsum = WSUM_W'(wp_r[0]) + WSUM_W'(wp_r[1]) + WSUM_W'(wp_r[2]);

  // Weight of the brightness term in the blend.
  assign inv_sat = SAT_ONE - INV_SAT_W'(sat);

  // Blend sum before the clamp.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      blend[c] = BL_W'(sx_r[c]) + BL_W'(ty_r);
    end
  end

  // Pipeline stages; each stage loads when its enable is high.
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (stage_en[0]) begin
        prod_r[c] <= $signed({1'b0, sample[c]}) * gain;
      end
      if (stage_en[1]) begin
        x_r[c] <= x_nxt[c];
      end
      if (stage_en[2]) begin
        wp_r[c] <= x_r[c] * WEIGHTS[c];
        x3_r[c] <= x_r[c];
      end
      if (stage_en[3]) begin
        x4_r[c] <= x3_r[c];
      end
      if (stage_en[4]) begin
        sx_r[c] <= x4_r[c] * sat;
      end
      if (stage_en[5]) begin
        if (blend[c] < 0) begin
          v_r[c] <= '0;
        end else if (blend[c] > BL_W'(V_ONE)) begin
          v_r[c] <= V_ONE;
        end else begin
          v_r[c] <= blend[c][V_W-1:0];
        end
      end
    end
    if (stage_en[3]) begin
      y_r <= wsum[WSUM_W-1:Y_FRAC];
    end
    if (stage_en[4]) begin
      ty_r <= y_r * inv_sat;
    end
  end

  assign chan_v = v_r;

endmodule

// ----- src/ptsd_merge.sv -----
`timescale 1ns / 1ps

module ptsd_merge (
  input  logic                              clk,
  input  logic [ptsd_pkg::MERGE_STAGES-1:0] stage_en,
  input  logic [ptsd_pkg::V_W-1:0]          lane_v [ptsd_pkg::NUM_LANES][ptsd_pkg::NUM_CH],
  output logic [ptsd_pkg::PIX_W-1:0]        pix    [ptsd_pkg::NUM_CH]
);
  import ptsd_pkg::*;

  logic [ACC_W-1:0] acc_nxt [NUM_CH];
  logic [ACC_W-1:0] acc_r   [NUM_CH];
  logic [SCL_W-1:0] scl     [NUM_CH];
  logic [PIX_W-1:0] pix_r   [NUM_CH];

  // Sum of the four clamped subsamples, then times 255.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      acc_nxt[c] = ACC_W'(lane_v[0][c]) + ACC_W'(lane_v[1][c])
                 + ACC_W'(lane_v[2][c]) + ACC_W'(lane_v[3][c]);
      scl[c] = SCL_W'({acc_r[c], 8'b0}) - SCL_W'(acc_r[c]);
    end
  end

  // Accumulator stage and output register.
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (stage_en[0]) begin
        acc_r[c] <= acc_nxt[c];
      end
      if (stage_en[1]) begin
        pix_r[c] <= scl[c][PIX_LSB +: PIX_W];
      end
    end
  end

  assign pix = pix_r;

endmodule
